// File: design/aet_pkg.sv
// Shared types and constants for the arithmetic expression tokenizer.
package aet_pkg;

   // token kinds
   localparam logic [2:0] KIND_LPAREN   = 3'd0;
   localparam logic [2:0] KIND_RPAREN   = 3'd1;
   localparam logic [2:0] KIND_CARET    = 3'd2;
   localparam logic [2:0] KIND_ASTERISK = 3'd3;
   localparam logic [2:0] KIND_SLASH    = 3'd4;
   localparam logic [2:0] KIND_PLUS     = 3'd5;
   localparam logic [2:0] KIND_MINUS    = 3'd6;
   localparam logic [2:0] KIND_NUMBER   = 3'd7;

   // source characters
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [7:0] CHAR_ASTERISK = 8'h2A;
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   localparam logic [7:0] FRAC_MAX = 8'hFF;

   typedef struct packed {
      logic [2:0]  kind;
      logic        neg;
      logic [31:0] mant;
      logic [7:0]  frac;
      logic        ovf;
      logic        last;
   } token_type;

endpackage

// File: design/arith_expr_tokenizer.sv
// Arithmetic expression tokenizer: longest-match lexer with a small token queue.
// Tokens are written into the registered token queue and leave rsp from its head.
// Throughput: one request per cycle while req_tready is high; a request that yields two tokens
// takes two queue slots, absorbed by a four-entry token queue (ready while two slots are free).
// Reset: synchronous, active high; clears the scan state and empties the queue.
// The lexer state is updated by one multiply-by-ten add and compare per request.
module arith_expr_tokenizer #(
   parameter int unsigned MANT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] is_negative, [32:1] mantissa,
                                    // [40:33] frac_digits, [41] value_overflow
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_MINUS     = 3'd1;
   localparam logic [2:0] PH_MINUS_DOT = 3'd2;
   localparam logic [2:0] PH_DOT       = 3'd3;
   localparam logic [2:0] PH_INT       = 3'd4;
   localparam logic [2:0] PH_INT_DOT   = 3'd5;
   localparam logic [2:0] PH_FRAC      = 3'd6;

   localparam int unsigned PW = MANT_BITS + 4;
   localparam logic [MANT_BITS-1:0] MANT_MAX = '1;

   logic [2:0]           phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic [MANT_BITS-1:0] acc_ff, acc_in;
   logic [7:0]           fc_ff, fc_in;
   logic                 ovf_ff, ovf_in;

   aet_pkg::token_type   queue_ff [4];
   logic [1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [2:0]           count_ff, count_in;

   logic       req_fire, rsp_fire;
   logic [7:0] c;
   logic       is_dig, is_dot, is_minus;
   logic [3:0] digit;
   logic       op_valid;
   logic [2:0] op_kind;

   logic       add_en, add_start, add_frac, start_neg;
   logic       emit_a, a_num, go_idle, emit_b, emit_c, c_num;
   logic [2:0] ph_lex;

   logic [MANT_BITS-1:0] acc_base, acc_add, acc_lex;
   logic [7:0]           fc_base, fc_lex;
   logic                 ovf_base, ovf_lex, neg_lex;
   logic [PW-1:0]        prod;

   aet_pkg::token_type tok_a, tok_bc, tok0, tok1;
   logic [1:0]         n_emit;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign c        = req_tdata;
   assign is_dig   = (c >= aet_pkg::CHAR_ZERO) && (c <= aet_pkg::CHAR_NINE);
   assign is_dot   = (c == aet_pkg::CHAR_DOT);
   assign is_minus = (c == aet_pkg::CHAR_MINUS);
   assign digit    = c[3:0];

   always_comb begin
      op_valid = 1'b1;
      op_kind  = aet_pkg::KIND_LPAREN;
      unique case (c)
         aet_pkg::CHAR_LPAREN:   op_kind = aet_pkg::KIND_LPAREN;
         aet_pkg::CHAR_RPAREN:   op_kind = aet_pkg::KIND_RPAREN;
         aet_pkg::CHAR_CARET:    op_kind = aet_pkg::KIND_CARET;
         aet_pkg::CHAR_ASTERISK: op_kind = aet_pkg::KIND_ASTERISK;
         aet_pkg::CHAR_SLASH:    op_kind = aet_pkg::KIND_SLASH;
         aet_pkg::CHAR_PLUS:     op_kind = aet_pkg::KIND_PLUS;
         default:                op_valid = 1'b0;
      endcase
   end

   // scan step: what the pending token does with this character
   always_comb begin
      ph_lex    = phase_ff;
      add_en    = 1'b0;
      add_start = 1'b0;
      add_frac  = 1'b0;
      start_neg = 1'b0;
      emit_a    = 1'b0;
      a_num     = 1'b0;
      go_idle   = 1'b0;
      emit_b    = 1'b0;
      unique case (phase_ff)
         PH_INT: begin
            if (is_dig) begin
               add_en = 1'b1;
            end else if (is_dot) begin
               ph_lex = PH_INT_DOT;
            end else begin
               emit_a  = 1'b1;
               a_num   = 1'b1;
               go_idle = 1'b1;
            end
         end
         PH_INT_DOT, PH_FRAC: begin
            if (is_dig) begin
               add_en   = 1'b1;
               add_frac = 1'b1;
               ph_lex   = PH_FRAC;
            end else begin
               emit_a  = 1'b1;
               a_num   = 1'b1;
               go_idle = 1'b1;
            end
         end
         PH_MINUS: begin
            if (is_dig) begin
               add_en    = 1'b1;
               add_start = 1'b1;
               start_neg = 1'b1;
               ph_lex    = PH_INT;
            end else if (is_dot) begin
               ph_lex = PH_MINUS_DOT;
            end else begin
               emit_a  = 1'b1;
               go_idle = 1'b1;
            end
         end
         PH_MINUS_DOT: begin
            if (is_dig) begin
               add_en    = 1'b1;
               add_start = 1'b1;
               start_neg = 1'b1;
               add_frac  = 1'b1;
               ph_lex    = PH_FRAC;
            end else begin
               emit_a  = 1'b1;
               go_idle = 1'b1;
            end
         end
         PH_DOT: begin
            if (is_dig) begin
               add_en    = 1'b1;
               add_start = 1'b1;
               add_frac  = 1'b1;
               ph_lex    = PH_FRAC;
            end else begin
               go_idle = 1'b1;
            end
         end
         default: go_idle = 1'b1;
      endcase
      // the terminating character is lexed again from idle
      if (go_idle) begin
         ph_lex = PH_IDLE;
         priority if (op_valid) begin
            emit_b = 1'b1;
         end else if (is_minus) begin
            ph_lex = PH_MINUS;
         end else if (is_dot) begin
            ph_lex = PH_DOT;
         end else if (is_dig) begin
            add_en    = 1'b1;
            add_start = 1'b1;
            ph_lex    = PH_INT;
         end else begin
            // unmatched byte is dropped
            ph_lex = PH_IDLE;
         end
      end
   end

   // saturating decimal accumulate: acc*10 + d, clamp when above all ones
   always_comb begin
      acc_base = add_start ? '0 : acc_ff;
      fc_base  = add_start ? 8'd0 : fc_ff;
      ovf_base = add_start ? 1'b0 : ovf_ff;
      neg_lex  = add_start ? start_neg : neg_ff;
      prod     = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) + PW'(digit);
      if (prod > {4'd0, MANT_MAX}) begin
         acc_add = MANT_MAX;
         ovf_lex = 1'b1;
      end else begin
         acc_add = prod[MANT_BITS-1:0];
         ovf_lex = ovf_base;
      end
      fc_lex = fc_base;
      if (add_frac) begin
         if (fc_base == aet_pkg::FRAC_MAX) begin
            ovf_lex = 1'b1;
         end else begin
            fc_lex = fc_base + 8'd1;
         end
      end
      acc_lex = acc_add;
      if (!add_en) begin
         acc_lex = acc_ff;
         fc_lex  = fc_ff;
         ovf_lex = ovf_ff;
         neg_lex = neg_ff;
      end
   end

   // end of source flushes whatever is still pending
   always_comb begin
      emit_c   = 1'b0;
      c_num    = 1'b0;
      phase_in = ph_lex;
      neg_in   = neg_lex;
      acc_in   = acc_lex;
      fc_in    = fc_lex;
      ovf_in   = ovf_lex;
      if (req_tlast) begin
         c_num  = (ph_lex == PH_INT) || (ph_lex == PH_INT_DOT) || (ph_lex == PH_FRAC);
         emit_c = c_num || (ph_lex == PH_MINUS) || (ph_lex == PH_MINUS_DOT);
         phase_in = PH_IDLE;
         neg_in   = 1'b0;
         acc_in   = '0;
         fc_in    = 8'd0;
         ovf_in   = 1'b0;
      end
   end

   always_comb begin
      tok_a      = '0;
      tok_a.kind = aet_pkg::KIND_MINUS;
      if (a_num) begin
         tok_a.kind = aet_pkg::KIND_NUMBER;
         tok_a.neg  = neg_ff;
         tok_a.mant = 32'(acc_ff);
         tok_a.frac = fc_ff;
         tok_a.ovf  = ovf_ff;
      end
      tok_bc = '0;
      if (emit_b) begin
         tok_bc.kind = op_kind;
      end else if (c_num) begin
         tok_bc.kind = aet_pkg::KIND_NUMBER;
         tok_bc.neg  = neg_lex;
         tok_bc.mant = 32'(acc_lex);
         tok_bc.frac = fc_lex;
         tok_bc.ovf  = ovf_lex;
      end else begin
         tok_bc.kind = aet_pkg::KIND_MINUS;
      end
      n_emit = {1'b0, emit_a} + {1'b0, emit_b || emit_c};
      tok0      = emit_a ? tok_a : tok_bc;
      tok0.last = (n_emit == 2'd1);
      tok1      = tok_bc;
      tok1.last = 1'b1;
   end

   assign count_in = count_ff + {1'b0, req_fire ? n_emit : 2'd0} - {2'd0, rsp_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         fc_ff     <= 8'd0;
         ovf_ff    <= 1'b0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (req_fire) begin
            phase_ff  <= phase_in;
            neg_ff    <= neg_in;
            acc_ff    <= acc_in;
            fc_ff     <= fc_in;
            ovf_ff    <= ovf_in;
            wr_ptr_ff <= wr_ptr_ff + n_emit;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (n_emit != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= tok0;
      end
      if (req_fire && (n_emit == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= tok1;
      end
   end

   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {6'd0, queue_ff[rd_ptr_ff].ovf, queue_ff[rd_ptr_ff].frac,
                        queue_ff[rd_ptr_ff].mant, queue_ff[rd_ptr_ff].neg};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("token queue overfilled");

   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> phase_ff == PH_IDLE && acc_ff == '0)
      else $error("scan state not cleared after end of source");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_fire |=> count_ff == $past(count_ff) + {1'b0, $past(n_emit)})
      else $error("queue count does not follow emitted tokens");

   a_op_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != aet_pkg::KIND_NUMBER |-> rsp_tdata == 48'd0)
      else $error("operator token carries number fields");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the arithmetic expression tokenizer.
`timescale 1ns / 1ps

module testbench;

   localparam int          MANT_BITS   = 32;
   localparam logic [63:0] MANT_LIMIT  = (64'd1 << MANT_BITS) - 64'd1;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLDOFF_AT  = 400;
   localparam int          HOLDOFF_LEN = 200;
   localparam int          QUIET_FROM  = 700;
   localparam int          QUIET_TO    = 1000;
   localparam logic [7:0]  CHAR_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_MINUS, SCAN_MINUS_DOT, SCAN_DOT, SCAN_INT, SCAN_INT_DOT, SCAN_FRAC
   } scan_state_type;

   typedef struct {
      logic [7:0] code;
      logic       eos;
      bit         drain;   // hold until all tokens are out before sending
   } src_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] char_code
   logic        req_tlast = 1'b0;  // end_of_source
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [0] is_negative, [32:1] mantissa,
                                   // [40:33] frac_digits, [41] value_overflow
   logic [2:0]  rsp_tuser;         // [2:0] token_kind
   logic        rsp_tlast;         // last_of_run

   src_char_type       char_q[$];
   aet_pkg::token_type token_q[$];
   aet_pkg::token_type step_tokens[$];
   bit                 drain_next = 0;

   // lexer shadow state
   scan_state_type scan_state = SCAN_IDLE;
   logic        num_neg = 1'b0;
   logic [63:0] num_accum = '0;
   logic [7:0]  num_frac = '0;
   logic        num_ovf = 1'b0;

   logic        req_taken = 1'b0;
   int          accepted_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 0;
   logic        quiet;

   logic [7:0]  op_chars[7] = '{aet_pkg::CHAR_LPAREN, aet_pkg::CHAR_RPAREN,
                                aet_pkg::CHAR_CARET, aet_pkg::CHAR_ASTERISK,
                                aet_pkg::CHAR_SLASH, aet_pkg::CHAR_PLUS,
                                aet_pkg::CHAR_MINUS};

   assign quiet = accepted_count >= QUIET_FROM && accepted_count < QUIET_TO;

   arith_expr_tokenizer #(.MANT_BITS(MANT_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------------------------------------------------------- lexer predictor

   function automatic bit is_digit(input logic [7:0] c);
      return c >= aet_pkg::CHAR_ZERO && c <= aet_pkg::CHAR_NINE;
   endfunction

   task automatic push_token(input logic [2:0] kind, input logic neg,
                             input logic [63:0] mant, input logic [7:0] frac, input logic ovf);
      aet_pkg::token_type t;
      t.kind = kind;
      t.neg  = neg;
      t.mant = mant[31:0];
      t.frac = frac;
      t.ovf  = ovf;
      t.last = 1'b0;
      step_tokens = {step_tokens, t};
   endtask

   task automatic push_number();
      push_token(aet_pkg::KIND_NUMBER, num_neg, num_accum, num_frac, num_ovf);
   endtask

   task automatic push_minus();
      push_token(aet_pkg::KIND_MINUS, 1'b0, '0, '0, 1'b0);
   endtask

   task automatic clear_number(input logic neg);
      num_neg   = neg;
      num_accum = '0;
      num_frac  = '0;
      num_ovf   = 1'b0;
   endtask

   // saturating mantissa *10 + digit; fraction count saturates separately
   task automatic accumulate_digit(input logic [7:0] c, input bit in_frac);
      logic [63:0] d;
      d = 64'(c - aet_pkg::CHAR_ZERO);
      if (num_accum > (MANT_LIMIT - d) / 64'd10) begin
         num_accum = MANT_LIMIT;
         num_ovf   = 1'b1;
      end else begin
         num_accum = num_accum * 64'd10 + d;
      end
      if (in_frac) begin
         if (num_frac == aet_pkg::FRAC_MAX) num_ovf = 1'b1;
         else num_frac = num_frac + 8'd1;
      end
   endtask

   task automatic scan_from_idle(input logic [7:0] c);
      scan_state = SCAN_IDLE;
      case (c)
         aet_pkg::CHAR_LPAREN:   push_token(aet_pkg::KIND_LPAREN, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_RPAREN:   push_token(aet_pkg::KIND_RPAREN, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_CARET:    push_token(aet_pkg::KIND_CARET, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_ASTERISK: push_token(aet_pkg::KIND_ASTERISK, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_SLASH:    push_token(aet_pkg::KIND_SLASH, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_PLUS:     push_token(aet_pkg::KIND_PLUS, 1'b0, '0, '0, 1'b0);
         aet_pkg::CHAR_MINUS:    scan_state = SCAN_MINUS;
         aet_pkg::CHAR_DOT:      scan_state = SCAN_DOT;
         default: begin
            if (is_digit(c)) begin
               clear_number(1'b0);
               accumulate_digit(c, 0);
               scan_state = SCAN_INT;
            end
         end
      endcase
   endtask

   task automatic scan_char(input logic [7:0] c);
      case (scan_state)
         SCAN_INT: begin
            if (is_digit(c)) accumulate_digit(c, 0);
            else if (c == aet_pkg::CHAR_DOT) scan_state = SCAN_INT_DOT;
            else begin
               push_number();
               scan_from_idle(c);
            end
         end
         SCAN_INT_DOT, SCAN_FRAC: begin
            if (is_digit(c)) begin
               accumulate_digit(c, 1);
               scan_state = SCAN_FRAC;
            end else begin
               push_number();
               scan_from_idle(c);
            end
         end
         SCAN_MINUS: begin
            if (is_digit(c)) begin
               clear_number(1'b1);
               accumulate_digit(c, 0);
               scan_state = SCAN_INT;
            end else if (c == aet_pkg::CHAR_DOT) scan_state = SCAN_MINUS_DOT;
            else begin
               push_minus();
               scan_from_idle(c);
            end
         end
         SCAN_MINUS_DOT: begin
            if (is_digit(c)) begin
               clear_number(1'b1);
               accumulate_digit(c, 1);
               scan_state = SCAN_FRAC;
            end else begin
               push_minus();
               scan_from_idle(c);
            end
         end
         SCAN_DOT: begin
            if (is_digit(c)) begin
               clear_number(1'b0);
               accumulate_digit(c, 1);
               scan_state = SCAN_FRAC;
            end else scan_from_idle(c);
         end
         default: scan_from_idle(c);
      endcase
   endtask

   // tokens caused by one request, last one flagged, appended to token_q
   task automatic predict_tokens(input logic [7:0] c, input logic eos);
      aet_pkg::token_type t;
      step_tokens.delete();
      scan_char(c);
      if (eos) begin
         if (scan_state inside {SCAN_INT, SCAN_INT_DOT, SCAN_FRAC}) push_number();
         else if (scan_state inside {SCAN_MINUS, SCAN_MINUS_DOT}) push_minus();
         scan_state = SCAN_IDLE;
         clear_number(1'b0);
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         t = step_tokens[i];
         if (i == step_tokens.size() - 1) t.last = 1'b1;
         token_q = {token_q, t};
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_char(input logic [7:0] c, input bit eos);
      src_char_type it;
      it.code = c;
      it.eos = eos;
      it.drain = drain_next;
      drain_next = 0;
      char_q = {char_q, it};
   endtask

   task automatic add_text(input string s, input bit eos_at_end);
      for (int i = 0; i < s.len(); i++) add_char(s[i], eos_at_end && i == s.len() - 1);
   endtask

   task automatic add_digits(input int count);
      repeat (count) add_char(aet_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 0);
   endtask

   task automatic add_number();
      int n_int;
      if ($urandom_range(0, 3) == 0) add_char(aet_pkg::CHAR_MINUS, 0);
      n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
      add_digits(n_int);
      if (n_int == 0 || $urandom_range(0, 2) == 0) begin
         add_char(aet_pkg::CHAR_DOT, 0);
         add_digits($urandom_range(n_int == 0 ? 1 : 0, 4));
      end
   endtask

   task automatic add_expression();
      int n_parts;
      logic [7:0] c;
      n_parts = $urandom_range(1, 8);
      repeat (n_parts) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_number();
            4, 5, 6:    add_char(op_chars[$urandom_range(0, 6)], 0);
            7:          add_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            8:          add_char(CHAR_SPACE, 0);
            default:    add_char(aet_pkg::CHAR_DOT, 0);
         endcase
      end
      c = $urandom_range(0, 1) ? op_chars[$urandom_range(0, 6)]
                               : aet_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      add_char(c, 1);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : driver
      src_char_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (char_q.size() == 0 || (char_q[0].drain && token_q.size() != 0)
             || (!quiet && $urandom_range(0, 99) < 13)) begin
            req_tvalid <= 1'b0;
         end else begin
            it = char_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.code;
            req_tlast  <= it.eos;
         end
      end
   end

   // sink: random stalls plus one long hold-off to back up the token queue
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1;
      end else begin
         rsp_tready <= quiet || $urandom_range(0, 99) >= 13;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      aet_pkg::token_type want;
      if (reset) begin
         req_taken      <= 1'b0;
         accepted_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               $display("%0t: unexpected token: expected none, actual kind %0d tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = token_q.pop_front();
               check_field("token_kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("is_negative", 32'(want.neg), 32'(rsp_tdata[0]));
               check_field("mantissa", want.mant, rsp_tdata[32:1]);
               check_field("frac_digits", 32'(want.frac), 32'(rsp_tdata[40:33]));
               check_field("value_overflow", 32'(want.ovf), 32'(rsp_tdata[41]));
               check_field("last_of_run", 32'(want.last), 32'(rsp_tlast));
            end
         end
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_tokens(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      bit mid_drain_set;
      bit timed_out;
      mid_drain_set = 0;

      // directed: every operator, lone minus, minus-dot, minus after a number,
      // unmatched bytes, flush of pending minus and lone dot, int dot then operator
      add_text("()^*/+-.)", 0);
      add_text("5-3", 1);
      add_char(8'hFF, 0);
      add_char(8'h00, 0);
      add_text("-", 1);
      add_text(".", 1);
      add_text("3.+", 0);
      add_text("-.5", 1);

      // random part; starts with mantissa and fraction saturation
      drain_next = 1;
      add_digits(14);
      add_char(aet_pkg::CHAR_PLUS, 0);
      add_char(aet_pkg::CHAR_ZERO + 8'd1, 0);
      add_char(aet_pkg::CHAR_DOT, 0);
      add_digits(260);
      add_char(aet_pkg::CHAR_RPAREN, 1);
      while (char_q.size() < 1250) begin
         if (!mid_drain_set && char_q.size() >= 1100) begin
            drain_next = 1;
            mid_drain_set = 1;
         end
         add_expression();
      end

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while ((char_q.size() != 0 || req_tvalid || token_q.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      timed_out = cycle_count >= CYCLE_LIMIT;
      if (!timed_out) repeat (10) @(posedge clock);

      if (!timed_out && error_count == 0) begin
         $display("** arith_expr_tokenizer: PASSED **");
      end else begin
         $display("** arith_expr_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
